// ----- src/sac_pkg.sv -----
// shared constants, types and register map of the six-axis admittance controller
package sac_pkg;

    localparam int NUM_AX    = 6;
    localparam int AXES      = 6;
    localparam int NUM_TRANS = 3;
    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 24;
    localparam int CFG_IDX_W = 3;
    localparam int STATE_W   = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_MASS_TRANS  = 3'd0,
        REG_INV_MASS_ROT    = 3'd1,
        REG_DAMPING         = 3'd2,
        REG_STIFFNESS_TRANS = 3'd3,
        REG_STIFFNESS_ROT   = 3'd4,
        REG_STEP_TIME       = 3'd5
    } t_reg_idx;

    localparam logic [GAIN_W-1:0] RST_INV_MASS_TRANS  = 24'd4096;
    localparam logic [GAIN_W-1:0] RST_INV_MASS_ROT    = 24'd32768;
    localparam logic [GAIN_W-1:0] RST_DAMPING         = 24'd6400;
    localparam logic [GAIN_W-1:0] RST_STIFFNESS_TRANS = 24'd8960;
    localparam logic [GAIN_W-1:0] RST_STIFFNESS_ROT   = 24'd1280;
    localparam logic [GAIN_W-1:0] RST_STEP_TIME       = 24'd33554;

    typedef struct packed {
        logic [GAIN_W-1:0] inv_mass_trans;
        logic [GAIN_W-1:0] inv_mass_rot;
        logic [GAIN_W-1:0] damping;
        logic [GAIN_W-1:0] stiffness_trans;
        logic [GAIN_W-1:0] stiffness_rot;
        logic [GAIN_W-1:0] step_time;
    } t_cfg;

    typedef struct packed {
        logic [GAIN_W-1:0] inv_mass;
        logic [GAIN_W-1:0] stiffness;
        logic [GAIN_W-1:0] damping;
        logic [GAIN_W-1:0] step_time;
    } t_gain;

    typedef struct packed {
        logic busy;
        logic done;
    } t_lane_sts;

endpackage

// ----- src/sac_intf.sv -----
// channel interfaces: wrench and setpoint in, command out, register writes
interface sac_in_if;
    import sac_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] force_x;
    logic signed [DATA_W-1:0] force_y;
    logic signed [DATA_W-1:0] force_z;
    logic signed [DATA_W-1:0] torque_x;
    logic signed [DATA_W-1:0] torque_y;
    logic signed [DATA_W-1:0] torque_z;
    logic signed [DATA_W-1:0] set_x;
    logic signed [DATA_W-1:0] set_y;
    logic signed [DATA_W-1:0] set_z;
    logic signed [DATA_W-1:0] set_rx;
    logic signed [DATA_W-1:0] set_ry;
    logic signed [DATA_W-1:0] set_rz;

    modport source (
        output valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
               set_x, set_y, set_z, set_rx, set_ry, set_rz,
        input  ready
    );
    modport sink (
        input  valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
               set_x, set_y, set_z, set_rx, set_ry, set_rz,
        output ready
    );
endinterface

interface sac_out_if;
    import sac_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] cmd_x;
    logic signed [DATA_W-1:0] cmd_y;
    logic signed [DATA_W-1:0] cmd_z;
    logic signed [DATA_W-1:0] cmd_rx;
    logic signed [DATA_W-1:0] cmd_ry;
    logic signed [DATA_W-1:0] cmd_rz;

    modport source (
        output valid, cmd_x, cmd_y, cmd_z, cmd_rx, cmd_ry, cmd_rz,
        input  ready
    );
    modport sink (
        input  valid, cmd_x, cmd_y, cmd_z, cmd_rx, cmd_ry, cmd_rz,
        output ready
    );
endinterface

interface sac_cfg_if;
    import sac_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [GAIN_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- src/six_axis_admittance_controller_top.sv -----
// top level of the six-axis admittance controller
//
// i_in carries one wrench sample and the matching six-axis setpoint per
// transfer; o_out returns one commanded pose per input transfer, in order.
// i_cfg writes the gain and step time registers by index; unknown indexes
// are dropped. write registers only while no sample is in flight.
// one lane per axis updates that axis's velocity and deflection; each lane
// runs five products through its one 25x21 multiplier, two halves apiece,
// each through states M0, M1, M2 and FIN, then CMD registers the command.
// i_in.ready drops while the lanes work and returns once their result
// moves out, so no new sample is taken until the last one is done.
// a finished command waits in the output register while the next sample
// runs; if o_out stalls longer, the lanes hold their result and i_in stays
// blocked until the output register frees up.
// reset: velocity and deflection clear to zero, registers take their
// default gains, the output register empties.
module six_axis_admittance_controller_top
    import sac_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    sac_in_if.sink     i_in,
    sac_cfg_if.sink    i_cfg,
    sac_out_if.source  o_out
);

    t_cfg                     w_cfg;
    t_lane_sts                w_sts   [NUM_AX];
    logic signed [DATA_W-1:0] w_force [NUM_AX];
    logic signed [DATA_W-1:0] w_setp  [NUM_AX];
    logic signed [DATA_W-1:0] w_cmd   [NUM_AX];
    logic [NUM_AX-1:0]        w_busy;
    logic [NUM_AX-1:0]        w_done;
    logic                     w_in_xfer;
    logic                     w_ack;

    assign w_force[0] = i_in.force_x;
    assign w_force[1] = i_in.force_y;
    assign w_force[2] = i_in.force_z;
    assign w_force[3] = i_in.torque_x;
    assign w_force[4] = i_in.torque_y;
    assign w_force[5] = i_in.torque_z;
    assign w_setp[0]  = i_in.set_x;
    assign w_setp[1]  = i_in.set_y;
    assign w_setp[2]  = i_in.set_z;
    assign w_setp[3]  = i_in.set_rx;
    assign w_setp[4]  = i_in.set_ry;
    assign w_setp[5]  = i_in.set_rz;

    assign i_in.ready = ~|w_busy;
    assign w_in_xfer  = i_in.valid && i_in.ready;

    sac_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    for (genvar g = 0; g < NUM_AX; g++) begin : g_axis
        if (g < AXES) begin : g_lane
            t_gain w_gain;

            assign w_gain.inv_mass  = (g < NUM_TRANS) ? w_cfg.inv_mass_trans
                                                      : w_cfg.inv_mass_rot;
            assign w_gain.stiffness = (g < NUM_TRANS) ? w_cfg.stiffness_trans
                                                      : w_cfg.stiffness_rot;
            assign w_gain.damping   = w_cfg.damping;
            assign w_gain.step_time = w_cfg.step_time;

            sac_lane u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_start (w_in_xfer),
                .i_force (w_force[g]),
                .i_setp  (w_setp[g]),
                .i_gain  (w_gain),
                .i_ack   (w_ack),
                .o_sts   (w_sts[g]),
                .o_cmd   (w_cmd[g])
            );
        end else begin : g_idle
            logic signed [DATA_W-1:0] r_setp;

            // axis without a lane passes its setpoint
            always_ff @(posedge i_clk) begin
                if (w_in_xfer) begin
                    r_setp <= w_setp[g];
                end
            end

            assign w_sts[g].busy = 1'b0;
            assign w_sts[g].done = 1'b1;
            assign w_cmd[g]      = r_setp;
        end

        assign w_busy[g] = w_sts[g].busy;
        assign w_done[g] = w_sts[g].done;
    end

    sac_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_all_done (&w_done),
        .i_cmd      (w_cmd),
        .o_ack      (w_ack),
        .o_out      (o_out)
    );

endmodule

// ----- src/sac_cfg.sv -----
// gain and step time registers written over the configuration channel
module sac_cfg
    import sac_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    sac_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inv_mass_trans  <= RST_INV_MASS_TRANS;
            r_cfg.inv_mass_rot    <= RST_INV_MASS_ROT;
            r_cfg.damping         <= RST_DAMPING;
            r_cfg.stiffness_trans <= RST_STIFFNESS_TRANS;
            r_cfg.stiffness_rot   <= RST_STIFFNESS_ROT;
            r_cfg.step_time       <= RST_STEP_TIME;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_INV_MASS_TRANS:  r_cfg.inv_mass_trans  <= i_cfg.data;
                REG_INV_MASS_ROT:    r_cfg.inv_mass_rot    <= i_cfg.data;
                REG_DAMPING:         r_cfg.damping         <= i_cfg.data;
                REG_STIFFNESS_TRANS: r_cfg.stiffness_trans <= i_cfg.data;
                REG_STIFFNESS_ROT:   r_cfg.stiffness_rot   <= i_cfg.data;
                REG_STEP_TIME:       r_cfg.step_time       <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

// ----- src/sac_lane.sv -----
// one axis: mass-spring-damper update on a shared split multiplier
module sac_lane
    import sac_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DATA_W-1:0] i_force,
    input  logic signed [DATA_W-1:0] i_setp,
    input  t_gain                    i_gain,
    input  logic                     i_ack,
    output t_lane_sts                o_sts,
    output logic signed [DATA_W-1:0] o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_M0, ST_M1, ST_M2, ST_FIN, ST_CMD, ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        PH_DV, PH_KX, PH_AM, PH_AT, PH_VT
    } t_phase;

    t_state r_state;
    t_phase r_phase;

    logic signed [STATE_W-1:0] r_vel;
    logic signed [STATE_W-1:0] r_def;
    logic signed [DATA_W-1:0]  r_force;
    logic signed [DATA_W-1:0]  r_setp;
    logic signed [DATA_W-1:0]  r_cmd;
    logic signed [45:0]        r_pp;
    logic signed [63:0]        r_acc;
    logic signed [48:0]        r_term;
    logic signed [39:0]        r_opnd;

    logic [GAIN_W:0]    w_a;
    logic signed [39:0] w_b;
    logic signed [20:0] w_mul_b;
    logic signed [45:0] w_pp;
    logic signed [50:0] w_kx_sum;
    logic signed [56:0] w_vel_sum;
    logic signed [56:0] w_def_sum;
    logic signed [32:0] w_cmd_sum;

    function automatic logic signed [39:0] f_sat40(input logic signed [55:0] v);
        logic signed [39:0] res;
        if (v[55:39] == {17{v[55]}}) begin
            res = v[39:0];
        end else begin
            res = v[55] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
        end
        return res;
    endfunction

    function automatic logic signed [47:0] f_sat48(input logic signed [56:0] v);
        logic signed [47:0] res;
        if (v[56:47] == {10{v[56]}}) begin
            res = v[47:0];
        end else begin
            res = v[56] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
        end
        return res;
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [32:0] v);
        logic signed [31:0] res;
        if (v[32] == v[31]) begin
            res = v[31:0];
        end else begin
            res = v[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
        end
        return res;
    endfunction

    // operand select per phase
    always_comb begin
        case (r_phase)
            PH_DV: begin
                w_a = {1'b0, i_gain.damping};
                w_b = {{8{r_vel[47]}}, r_vel[47:16]};
            end
            PH_KX: begin
                w_a = {1'b0, i_gain.stiffness};
                w_b = {{8{r_def[47]}}, r_def[47:16]};
            end
            PH_AM: begin
                w_a = {1'b0, i_gain.inv_mass};
                w_b = r_opnd;
            end
            PH_AT: begin
                w_a = {1'b0, i_gain.step_time};
                w_b = r_opnd;
            end
            PH_VT: begin
                w_a = {1'b0, i_gain.step_time};
                w_b = {{8{r_vel[47]}}, r_vel[47:16]};
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    // low half unsigned, high half signed
    assign w_mul_b = (r_state == ST_M0) ? $signed({1'b0, w_b[19:0]})
                                        : $signed({w_b[39], w_b[39:20]});
    assign w_pp    = $signed(w_a) * w_mul_b;

    assign w_kx_sum  = 51'(r_force) - 51'(r_term) - 51'($signed(r_acc[56:8]));
    assign w_vel_sum = 57'($signed(r_acc[63:8])) + 57'(r_vel);
    assign w_def_sum = 57'($signed(r_acc[56:8])) + 57'(r_def);
    assign w_cmd_sum = 33'(r_setp) + 33'($signed(r_def[47:16]));

    assign o_sts.busy = (r_state != ST_IDLE);
    assign o_sts.done = (r_state == ST_DONE);
    assign o_cmd      = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_DV;
            r_vel   <= '0;
            r_def   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_force <= i_force;
                        r_setp  <= i_setp;
                        r_phase <= PH_DV;
                        r_state <= ST_M0;
                    end
                end
                ST_M0: begin
                    r_pp    <= w_pp;
                    r_state <= ST_M1;
                end
                ST_M1: begin
                    r_pp    <= w_pp;
                    r_acc   <= {{18{r_pp[45]}}, r_pp};
                    r_state <= ST_M2;
                end
                ST_M2: begin
                    r_acc   <= r_acc + {r_pp[43:0], 20'b0};
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    case (r_phase)
                        PH_DV: begin
                            r_term  <= $signed(r_acc[56:8]);
                            r_phase <= PH_KX;
                            r_state <= ST_M0;
                        end
                        PH_KX: begin
                            r_opnd  <= f_sat40(56'(w_kx_sum));
                            r_phase <= PH_AM;
                            r_state <= ST_M0;
                        end
                        PH_AM: begin
                            r_opnd  <= f_sat40(56'($signed(r_acc[63:16])));
                            r_phase <= PH_AT;
                            r_state <= ST_M0;
                        end
                        PH_AT: begin
                            r_vel   <= f_sat48(w_vel_sum);
                            r_phase <= PH_VT;
                            r_state <= ST_M0;
                        end
                        PH_VT: begin
                            r_def   <= f_sat48(w_def_sum);
                            r_phase <= PH_DV;
                            r_state <= ST_CMD;
                        end
                        default: begin
                            r_phase <= PH_DV;
                            r_state <= ST_IDLE;
                        end
                    endcase
                end
                ST_CMD: begin
                    r_cmd   <= f_sat32(w_cmd_sum);
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (i_ack) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- src/sac_merge.sv -----
// collects the six axis commands into the output register
module sac_merge
    import sac_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_all_done,
    input  logic signed [DATA_W-1:0] i_cmd [NUM_AX],
    output logic                     o_ack,
    sac_out_if.source                o_out
);

    logic                     r_valid;
    logic signed [DATA_W-1:0] r_cmd [NUM_AX];

    assign o_ack = i_all_done && (!r_valid || o_out.ready);

    assign o_out.valid  = r_valid;
    assign o_out.cmd_x  = r_cmd[0];
    assign o_out.cmd_y  = r_cmd[1];
    assign o_out.cmd_z  = r_cmd[2];
    assign o_out.cmd_rx = r_cmd[3];
    assign o_out.cmd_ry = r_cmd[4];
    assign o_out.cmd_rz = r_cmd[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ack) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ack) begin
            r_cmd <= i_cmd;
        end
    end

endmodule

// ----- bench/testbench.sv -----
// self-checking testbench for the six-axis admittance controller
`timescale 1ns / 100ps

module testbench;
    import sac_pkg::*;

    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES     = 30;
    localparam int RANDOM_PER_PHASE = 104;

    typedef logic [NUM_AX-1:0][DATA_W-1:0] t_pose;

    typedef struct packed {
        t_pose wrench;
        t_pose setp;
    } t_sample;

    class pose_predictor;
        t_cfg                      gains;
        logic signed [STATE_W-1:0] velocity [NUM_AX];
        logic signed [STATE_W-1:0] deflection [NUM_AX];
        t_pose                     pending_cmds [$];
        int                        samples;
        int                        commands;
        int                        errors;

        function new();
            gains.inv_mass_trans  = RST_INV_MASS_TRANS;
            gains.inv_mass_rot    = RST_INV_MASS_ROT;
            gains.damping         = RST_DAMPING;
            gains.stiffness_trans = RST_STIFFNESS_TRANS;
            gains.stiffness_rot   = RST_STIFFNESS_ROT;
            gains.step_time       = RST_STEP_TIME;
            foreach (velocity[a]) begin
                velocity[a]   = '0;
                deflection[a] = '0;
            end
            samples  = 0;
            commands = 0;
            errors   = 0;
        endfunction

        function longint clamp(longint v, int bits);
            longint hi;
            hi = (longint'(1) <<< (bits - 1)) - 1;
            if (v > hi) begin
                return hi;
            end
            if (v < -hi - 1) begin
                return -hi - 1;
            end
            return v;
        endfunction

        function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
            case (idx)
                REG_INV_MASS_TRANS:  gains.inv_mass_trans  = data;
                REG_INV_MASS_ROT:    gains.inv_mass_rot    = data;
                REG_DAMPING:         gains.damping         = data;
                REG_STIFFNESS_TRANS: gains.stiffness_trans = data;
                REG_STIFFNESS_ROT:   gains.stiffness_rot   = data;
                REG_STEP_TIME:       gains.step_time       = data;
                default: ;
            endcase
        endfunction

        function void note_sample(t_sample s);
            t_pose  cmd;
            longint f, sp, im, k, d, dt, sum, acc, v, x, c;
            d  = longint'(gains.damping);
            dt = longint'(gains.step_time);
            for (int a = 0; a < NUM_AX; a++) begin
                f  = longint'($signed(s.wrench[a]));
                sp = longint'($signed(s.setp[a]));
                if (a < AXES) begin
                    im = (a < NUM_TRANS) ? longint'(gains.inv_mass_trans)
                                         : longint'(gains.inv_mass_rot);
                    k  = (a < NUM_TRANS) ? longint'(gains.stiffness_trans)
                                         : longint'(gains.stiffness_rot);
                    sum = clamp(f - ((d * (longint'(velocity[a]) >>> 16)) >>> 8)
                                  - ((k * (longint'(deflection[a]) >>> 16)) >>> 8), 40);
                    acc = clamp((im * sum) >>> 16, 40);
                    v = clamp(longint'(velocity[a]) + ((acc * dt) >>> 8), 48);
                    x = clamp(longint'(deflection[a]) + (((v >>> 16) * dt) >>> 8), 48);
                    velocity[a]   = v[STATE_W-1:0];
                    deflection[a] = x[STATE_W-1:0];
                    c = clamp(sp + (x >>> 16), 32);
                    cmd[a] = c[DATA_W-1:0];
                end else begin
                    cmd[a] = s.setp[a];
                end
            end
            pending_cmds.push_back(cmd);
            samples++;
        endfunction

        function void check_cmd(t_pose got);
            t_pose want;
            if (pending_cmds.size() == 0) begin
                errors++;
                $display("%0t: command with no sample pending, got x %0d", $time,
                         $signed(got[0]));
                return;
            end
            want = pending_cmds.pop_front();
            commands++;
            for (int a = 0; a < NUM_AX; a++) begin
                if (got[a] !== want[a]) begin
                    errors++;
                    $display("%0t: cmd axis %0d expected %0d got %0d", $time, a,
                             $signed(want[a]), $signed(got[a]));
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    sac_in_if  in_ch ();
    sac_cfg_if cfg_ch ();
    sac_out_if out_ch ();

    six_axis_admittance_controller_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_out   (out_ch.source)
    );

    pose_predictor pred = new();
    int in_gap_max    = 10;
    int out_stall_max = 10;
    int reg_writes    = 0;
    int settings_used = 1;
    int idle_cycles   = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] spread(int unsigned half);
        return $urandom_range(0, 2 * half) - half;
    endfunction

    function automatic t_sample uniform_sample(logic [DATA_W-1:0] w, logic [DATA_W-1:0] sp);
        t_sample s;
        for (int a = 0; a < NUM_AX; a++) begin
            s.wrench[a] = w;
            s.setp[a]   = sp;
        end
        return s;
    endfunction

    function automatic t_sample random_sample();
        t_sample     s;
        int unsigned kind;
        kind = $urandom_range(0, 9);
        for (int a = 0; a < NUM_AX; a++) begin
            case (kind)
                6, 7: begin
                    s.wrench[a] = $urandom;
                    s.setp[a]   = $urandom;
                end
                8: begin
                    s.wrench[a] = $urandom;
                    s.setp[a]   = ($urandom_range(0, 1) ? 32'h7FFF_0000 : 32'h8000_0000)
                                  + $urandom_range(0, 16'hFFFF);
                end
                9: begin
                    s.wrench[a] = '0;
                    s.setp[a]   = spread(1 << 22);
                end
                default: begin
                    s.wrench[a] = spread(1 << 20);
                    s.setp[a]   = spread(1 << 22);
                end
            endcase
        end
        return s;
    endfunction

    function automatic t_cfg all_gains(logic [GAIN_W-1:0] v);
        t_cfg g;
        g.inv_mass_trans  = v;
        g.inv_mass_rot    = v;
        g.damping         = v;
        g.stiffness_trans = v;
        g.stiffness_rot   = v;
        g.step_time       = v;
        return g;
    endfunction

    function automatic t_cfg default_gains();
        t_cfg g;
        g.inv_mass_trans  = RST_INV_MASS_TRANS;
        g.inv_mass_rot    = RST_INV_MASS_ROT;
        g.damping         = RST_DAMPING;
        g.stiffness_trans = RST_STIFFNESS_TRANS;
        g.stiffness_rot   = RST_STIFFNESS_ROT;
        g.step_time       = RST_STEP_TIME;
        return g;
    endfunction

    function automatic t_cfg random_gains(logic [GAIN_W-1:0] mass_max,
                                          logic [GAIN_W-1:0] spring_max,
                                          logic [GAIN_W-1:0] step_max);
        t_cfg g;
        g.inv_mass_trans  = GAIN_W'($urandom_range(0, mass_max));
        g.inv_mass_rot    = GAIN_W'($urandom_range(0, mass_max));
        g.damping         = GAIN_W'($urandom_range(0, spring_max));
        g.stiffness_trans = GAIN_W'($urandom_range(0, spring_max));
        g.stiffness_rot   = GAIN_W'($urandom_range(0, spring_max));
        g.step_time       = GAIN_W'($urandom_range(1, step_max));
        return g;
    endfunction

    task automatic send_sample(t_sample s);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        repeat (gap) @(negedge i_clk);
        in_ch.force_x  = s.wrench[0];
        in_ch.force_y  = s.wrench[1];
        in_ch.force_z  = s.wrench[2];
        in_ch.torque_x = s.wrench[3];
        in_ch.torque_y = s.wrench[4];
        in_ch.torque_z = s.wrench[5];
        in_ch.set_x    = s.setp[0];
        in_ch.set_y    = s.setp[1];
        in_ch.set_z    = s.setp[2];
        in_ch.set_rx   = s.setp[3];
        in_ch.set_ry   = s.setp[4];
        in_ch.set_rz   = s.setp[5];
        in_ch.valid    = 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pred.note_sample(s);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pred.pending_cmds.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        cfg_ch.valid = 1'b1;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        pred.apply_write(idx, data);
        reg_writes++;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic apply_gains(t_cfg g);
        wait_drained();
        write_register(REG_INV_MASS_TRANS, g.inv_mass_trans);
        write_register(REG_INV_MASS_ROT, g.inv_mass_rot);
        write_register(REG_DAMPING, g.damping);
        write_register(REG_STIFFNESS_TRANS, g.stiffness_trans);
        write_register(REG_STIFFNESS_ROT, g.stiffness_rot);
        write_register(REG_STEP_TIME, g.step_time);
        settings_used++;
    endtask

    task automatic write_spare_indexes();
        write_register(IDX_SPARE_LO, GAIN_W'($urandom));
        write_register(IDX_SPARE_HI, GAIN_W'($urandom));
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 64 == 0) begin
                in_gap_max = $urandom_range(0, 1) ? 10 : 0;
            end
            if ($urandom_range(0, 49) == 0) begin
                wait_drained();
            end
            send_sample(random_sample());
        end
    endtask

    task automatic run_directed();
        t_sample s;
        send_sample(uniform_sample('0, '0));
        repeat (4) send_sample(uniform_sample(32'h7FFF_FFFF, '0));
        // push deflection past the top of the setpoint range
        send_sample(uniform_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF));
        repeat (10) send_sample(uniform_sample(32'h8000_0000, '0));
        send_sample(uniform_sample(32'h8000_0000, 32'h8000_0000));
        send_sample(uniform_sample(32'h5555_5555, 32'hAAAA_AAAA));
        send_sample(uniform_sample(32'hAAAA_AAAA, 32'h5555_5555));
        for (int a = 0; a < NUM_AX; a++) begin
            s = uniform_sample('0, '0);
            s.wrench[a] = 32'h0100_0000;
            send_sample(s);
        end
    endtask

    initial begin
        t_pose got;
        int    seen;
        int    stall;
        seen = 0;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (seen % 64 == 0) begin
                out_stall_max = $urandom_range(0, 1) ? 10 : 0;
            end
            stall = $urandom_range(0, out_stall_max);
            repeat (stall) @(negedge i_clk);
            out_ch.ready = 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            got[0] = out_ch.cmd_x;
            got[1] = out_ch.cmd_y;
            got[2] = out_ch.cmd_z;
            got[3] = out_ch.cmd_rx;
            got[4] = out_ch.cmd_ry;
            got[5] = out_ch.cmd_rz;
            pred.check_cmd(got);
            seen++;
            @(negedge i_clk);
            out_ch.ready = 1'b0;
        end
    end

    initial begin
        t_cfg g;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.force_x  = '0;
        in_ch.force_y  = '0;
        in_ch.force_z  = '0;
        in_ch.torque_x = '0;
        in_ch.torque_y = '0;
        in_ch.torque_z = '0;
        in_ch.set_x    = '0;
        in_ch.set_y    = '0;
        in_ch.set_z    = '0;
        in_ch.set_rx   = '0;
        in_ch.set_ry   = '0;
        in_ch.set_rz   = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();

        apply_gains(all_gains('1));
        write_spare_indexes();
        run_random(RANDOM_PER_PHASE);

        // zero step time holds the state
        apply_gains(all_gains('0));
        run_random(RANDOM_PER_PHASE);

        g = default_gains();
        g.step_time = 24'd1;
        apply_gains(g);
        run_random(RANDOM_PER_PHASE);

        apply_gains(random_gains('1, '1, '1));
        run_random(RANDOM_PER_PHASE);

        apply_gains(default_gains());
        run_random(RANDOM_PER_PHASE);

        apply_gains(random_gains(24'h02_0000, 24'h00_4000, 24'h02_0000));
        write_spare_indexes();
        run_random(RANDOM_PER_PHASE);

        // pure integrator, no spring or damper
        g = all_gains('0);
        g.inv_mass_trans = '1;
        g.inv_mass_rot   = '1;
        g.step_time      = RST_STEP_TIME;
        apply_gains(g);
        run_random(RANDOM_PER_PHASE);

        g = default_gains();
        g.step_time = '1;
        apply_gains(g);
        run_random(RANDOM_PER_PHASE);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d samples in, %0d commands checked, %0d gain settings, %0d writes",
                 pred.samples, pred.commands, settings_used, reg_writes);
        $display("summary: %0d field mismatches", pred.errors);
        if (pred.errors == 0 && pred.pending_cmds.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- six_axis_admittance_controller_top.f -----
src/sac_pkg.sv
src/sac_intf.sv
src/sac_cfg.sv
src/sac_lane.sv
src/sac_merge.sv
src/six_axis_admittance_controller_top.sv
bench/testbench.sv
